// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file
// depends on nothing; expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define NPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define NPS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/nps_pkg.sv
// types, constants and register codes of the nearest point search unit
// depends on nothing
package nps_pkg;

	localparam int MAX_POINTS_DEF  = 64;
	localparam int COORD_BITS_DEF  = 12;
	localparam int QCOORD_BITS     = 12;
	localparam int FRAC_BITS       = 16;
	localparam int SIZE_BITS       = 13;
	localparam int ID_BITS         = 8;
	localparam int COUNT_BITS      = 7;
	localparam int LIMIT_BITS      = 24;
	localparam int DIST_OUT_BITS   = 25;
	localparam int INDEX_BITS      = 6;
	localparam int PCOORD_BITS     = 12;
	localparam int APB_ADDR_BITS   = 4;
	localparam int APB_DATA_BITS   = 32;
	localparam int MAP_MAX         = 4096;
	localparam int SEARCH_CEILING  = 10000000;

	localparam logic [SIZE_BITS-1:0]  MAP_WIDTH_RST      = 13'd1024;
	localparam logic [SIZE_BITS-1:0]  MAP_HEIGHT_RST     = 13'd1024;
	localparam logic [COUNT_BITS-1:0] POINT_COUNT_RST    = 7'd0;
	localparam logic [LIMIT_BITS-1:0] DISTANCE_LIMIT_RST = 24'd1600;

	localparam logic REQ_STORE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [1:0] {
		REG_MAP_WIDTH,
		REG_MAP_HEIGHT,
		REG_POINT_COUNT,
		REG_DISTANCE_LIMIT
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE_X,
		ST_SCALE_Y,
		ST_SEARCH,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// control that travels with one table entry through the distance pipeline
	typedef struct packed {
		logic valid;
		logic last;
	} pipe_ctl_t;

endpackage

// File: rtl/core/nps_ram.sv
// generic simple dual port ram, one write and one registered read port
// depends on nothing
module nps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/nps_dist_unit.sv
// squared distance pipeline: absolute differences, squares, sum
// depends on nps_pkg
module nps_dist_unit #(
	parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF,
	localparam int DW  = (COORD_BITS > nps_pkg::QCOORD_BITS) ? COORD_BITS
		: nps_pkg::QCOORD_BITS,
	localparam int DSW = 2 * DW + 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  nps_pkg::pipe_ctl_t              ctl_in,
	input  logic [nps_pkg::QCOORD_BITS-1:0] qx,
	input  logic [nps_pkg::QCOORD_BITS-1:0] qy,
	input  logic [COORD_BITS-1:0]           px,
	input  logic [COORD_BITS-1:0]           py,
	input  logic [nps_pkg::ID_BITS-1:0]     id_in,
	output nps_pkg::pipe_ctl_t              ctl_out,
	output logic [DSW-1:0]                  sum_out,
	output logic [nps_pkg::ID_BITS-1:0]     id_out
);

	logic [DW-1:0] ax, bx, ay, by, dx, dy;
	logic [DW-1:0] dx_s2, dy_s2;
	logic [2*DW-1:0] sqx_s3, sqy_s3;
	logic [nps_pkg::ID_BITS-1:0] id_s2, id_s3;
	nps_pkg::pipe_ctl_t ctl_s2, ctl_s3;

	always_comb begin
		ax = DW'(qx);
		bx = DW'(px);
		ay = DW'(qy);
		by = DW'(py);
		dx = (ax >= bx) ? (ax - bx) : (bx - ax);
		dy = (ay >= by) ? (ay - by) : (by - ay);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_in;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2  <= dx;
		dy_s2  <= dy;
		id_s2  <= id_in;
		sqx_s3 <= (2*DW)'(dx_s2) * (2*DW)'(dx_s2);
		sqy_s3 <= (2*DW)'(dy_s2) * (2*DW)'(dy_s2);
		id_s3  <= id_s2;
	end

	assign sum_out = DSW'(sqx_s3) + DSW'(sqy_s3);
	assign ctl_out = ctl_s3;
	assign id_out  = id_s3;

endmodule

// File: rtl/core/nearest_point_search_unit.sv
// top level of the nearest point search unit
// depends on nps_pkg, nps_ram and nps_dist_unit
//
// Keeps a table of up to MAX_POINTS points (pixel x, pixel y, 8-bit id) in one
// ram and answers nearest point queries over its first point_count entries
// (capped at MAX_POINTS). A store transaction (req_type 0) writes one entry
// and gives no result; slots at or beyond MAX_POINTS are dropped. A query
// transaction (req_type 1) scales its Q0.16 position by the map size with
// truncation (map size saturates at 4096), then streams the entries through a
// single squared distance pipeline at one entry per cycle and keeps the first
// least distance. The result reports found only when that distance is strictly
// below both distance_limit and 10000000; nearest_id is zero on a miss and
// nearest_distance_sq is zero when no entry is searched. A query scales x then
// y on one shared multiplier, reads the entries on the ram read port, passes
// the read data through the distance pipeline to the running minimum and then
// loads the result; the input is stalled meanwhile, and an output register
// holds a finished result while the next transaction comes in.
// The user must write registers over the apb port only while the unit is
// idle, which the unit does not enforce; entries must be stored before a
// query searches them.
module nearest_point_search_unit #(
	parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                req_type,
	input  logic [nps_pkg::INDEX_BITS-1:0]      entry_index,
	input  logic [nps_pkg::PCOORD_BITS-1:0]     point_x,
	input  logic [nps_pkg::PCOORD_BITS-1:0]     point_y,
	input  logic [nps_pkg::ID_BITS-1:0]         point_id,
	input  logic [nps_pkg::FRAC_BITS-1:0]       query_x,
	input  logic [nps_pkg::FRAC_BITS-1:0]       query_y,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                found,
	output logic [nps_pkg::ID_BITS-1:0]         nearest_id,
	output logic [nps_pkg::DIST_OUT_BITS-1:0]   nearest_distance_sq,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [nps_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [nps_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [nps_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                pready
);

	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int NW   = (CW > nps_pkg::COUNT_BITS) ? CW : nps_pkg::COUNT_BITS;
	localparam int DW   = (COORD_BITS > nps_pkg::QCOORD_BITS) ? COORD_BITS
		: nps_pkg::QCOORD_BITS;
	localparam int DSW  = 2 * DW + 1;
	localparam int RW   = 2 * COORD_BITS + nps_pkg::ID_BITS;
	localparam int PW   = nps_pkg::FRAC_BITS + nps_pkg::SIZE_BITS;
	localparam int QC   = nps_pkg::QCOORD_BITS;
	localparam int FB   = nps_pkg::FRAC_BITS;

	// configuration registers
	logic [nps_pkg::SIZE_BITS-1:0]  map_width_q, map_height_q;
	logic [nps_pkg::COUNT_BITS-1:0] point_count_q;
	logic [nps_pkg::LIMIT_BITS-1:0] distance_limit_q;

	logic cfg_we;
	nps_pkg::cfg_reg_t cfg_sel;

	assign pready  = 1'b1;
	assign cfg_sel = nps_pkg::cfg_reg_t'(paddr[3:2]);
	assign cfg_we  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q      <= nps_pkg::MAP_WIDTH_RST;
			map_height_q     <= nps_pkg::MAP_HEIGHT_RST;
			point_count_q    <= nps_pkg::POINT_COUNT_RST;
			distance_limit_q <= nps_pkg::DISTANCE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_sel)
				nps_pkg::REG_MAP_WIDTH: begin
					map_width_q <= pwdata[nps_pkg::SIZE_BITS-1:0];
				end
				nps_pkg::REG_MAP_HEIGHT: begin
					map_height_q <= pwdata[nps_pkg::SIZE_BITS-1:0];
				end
				nps_pkg::REG_POINT_COUNT: begin
					point_count_q <= pwdata[nps_pkg::COUNT_BITS-1:0];
				end
				nps_pkg::REG_DISTANCE_LIMIT: begin
					distance_limit_q <= pwdata[nps_pkg::LIMIT_BITS-1:0];
				end
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			nps_pkg::REG_MAP_WIDTH:      prdata = nps_pkg::APB_DATA_BITS'(map_width_q);
			nps_pkg::REG_MAP_HEIGHT:     prdata = nps_pkg::APB_DATA_BITS'(map_height_q);
			nps_pkg::REG_POINT_COUNT:    prdata = nps_pkg::APB_DATA_BITS'(point_count_q);
			nps_pkg::REG_DISTANCE_LIMIT: prdata = nps_pkg::APB_DATA_BITS'(distance_limit_q);
		endcase
	end

	// sequencer
	nps_pkg::state_t state_q, state_d;
	logic accept, store_we, query_go, issue, last_issue, load_out, scale_y_sel;

	logic [FB-1:0] qfx_q, qfy_q;
	logic [QC-1:0] qx_q, qy_q;
	logic [NW-1:0] n_q, n_cap, pc_ext, addr_q;

	assign accept   = in_valid && !in_stall;
	assign store_we = accept && (req_type == nps_pkg::REQ_STORE)
		&& (32'(entry_index) < MAX_POINTS);
	assign query_go = accept && (req_type == nps_pkg::REQ_QUERY);

	// number of entries searched, capped at the table depth
	assign pc_ext     = NW'(point_count_q);
	assign n_cap      = (pc_ext > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : pc_ext;
	assign last_issue = (addr_q == (n_q - NW'(1)));

	nps_pkg::pipe_ctl_t ctl_s1, dist_ctl;
	logic [DSW-1:0] dist_sum;
	logic [nps_pkg::ID_BITS-1:0] dist_id;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = (state_q != nps_pkg::ST_IDLE);
		issue       = 1'b0;
		load_out    = 1'b0;
		scale_y_sel = (state_q == nps_pkg::ST_SCALE_Y);
		unique case (state_q)
			nps_pkg::ST_IDLE: begin
				if (in_valid && req_type == nps_pkg::REQ_QUERY) begin
					state_d = nps_pkg::ST_SCALE_X;
				end
			end
			nps_pkg::ST_SCALE_X: begin
				state_d = nps_pkg::ST_SCALE_Y;
			end
			nps_pkg::ST_SCALE_Y: begin
				state_d = (n_q == '0) ? nps_pkg::ST_FINISH : nps_pkg::ST_SEARCH;
			end
			nps_pkg::ST_SEARCH: begin
				issue = 1'b1;
				if (last_issue) begin
					state_d = nps_pkg::ST_DRAIN;
				end
			end
			nps_pkg::ST_DRAIN: begin
				if (dist_ctl.valid && dist_ctl.last) begin
					state_d = nps_pkg::ST_FINISH;
				end
			end
			nps_pkg::ST_FINISH: begin
				// wait for the output register to free up
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = nps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nps_pkg::ST_IDLE;
			end
		endcase
	end

	// shared scaling multiplier, x then y
	logic [FB-1:0] scale_frac;
	logic [nps_pkg::SIZE_BITS-1:0] scale_size_raw, scale_size;
	logic [PW-1:0] scale_prod;

	always_comb begin
		scale_frac     = scale_y_sel ? qfy_q : qfx_q;
		scale_size_raw = scale_y_sel ? map_height_q : map_width_q;
		scale_size     = (scale_size_raw > nps_pkg::SIZE_BITS'(nps_pkg::MAP_MAX))
			? nps_pkg::SIZE_BITS'(nps_pkg::MAP_MAX) : scale_size_raw;
		scale_prod     = PW'(scale_frac) * PW'(scale_size);
	end

	// query context and entry address counter
	always_ff @(posedge clk) begin
		if (query_go) begin
			qfx_q <= query_x;
			qfy_q <= query_y;
			n_q   <= n_cap;
		end
		if (state_q == nps_pkg::ST_SCALE_X) begin
			qx_q <= scale_prod[FB+QC-1:FB];
		end
		if (state_q == nps_pkg::ST_SCALE_Y) begin
			qy_q <= scale_prod[FB+QC-1:FB];
		end
		if (query_go) begin
			addr_q <= '0;
		end else if (issue) begin
			addr_q <= addr_q + NW'(1);
		end
	end

	// point table
	logic [RW-1:0] ram_wdata, ram_rdata;
	logic [COORD_BITS-1:0] rd_x, rd_y;
	logic [nps_pkg::ID_BITS-1:0] rd_id;

	assign ram_wdata = {COORD_BITS'(point_x), COORD_BITS'(point_y), point_id};
	assign {rd_x, rd_y, rd_id} = ram_rdata;

	nps_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (store_we),
		.waddr (AW'(entry_index)),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (addr_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// read data is valid in the cycle after issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= issue;
			ctl_s1.last  <= issue && last_issue;
		end
	end

	nps_dist_unit #(
		.COORD_BITS (COORD_BITS)
	) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s1),
		.qx      (qx_q),
		.qy      (qy_q),
		.px      (rd_x),
		.py      (rd_y),
		.id_in   (rd_id),
		.ctl_out (dist_ctl),
		.sum_out (dist_sum),
		.id_out  (dist_id)
	);

	// running minimum, first entry wins a tie
	logic any_q;
	logic [DSW-1:0] best_q;
	logic [nps_pkg::ID_BITS-1:0] best_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
		end else if (query_go) begin
			any_q <= 1'b0;
		end else if (dist_ctl.valid) begin
			any_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (query_go) begin
			best_q    <= '0;
			best_id_q <= '0;
		end else if (dist_ctl.valid && (!any_q || dist_sum < best_q)) begin
			best_q    <= dist_sum;
			best_id_q <= dist_id;
		end
	end

	// result register
	logic hit;
	logic found_q;
	logic [nps_pkg::ID_BITS-1:0] nearest_id_q;
	logic [nps_pkg::DIST_OUT_BITS-1:0] dist_q;

	assign hit = any_q && (best_q < DSW'(nps_pkg::SEARCH_CEILING))
		&& (best_q < DSW'(distance_limit_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			found_q      <= hit;
			nearest_id_q <= hit ? best_id_q : '0;
			dist_q       <= best_q[nps_pkg::DIST_OUT_BITS-1:0];
		end
	end

	assign out_valid           = out_valid_q;
	assign found               = found_q;
	assign nearest_id          = nearest_id_q;
	assign nearest_distance_sq = dist_q;

endmodule

// File: rtl/core/nps_checker.sv
// port level checks of the nearest point search unit, bound to the top level
// depends on nps_pkg and assert_macros.svh
`include "assert_macros.svh"

module nps_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                req_type,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                found,
	input logic [nps_pkg::ID_BITS-1:0]         nearest_id,
	input logic [nps_pkg::DIST_OUT_BITS-1:0]   nearest_distance_sq
);

	// a stalled result holds
	`NPS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(found) && $stable(nearest_id) && $stable(nearest_distance_sq), "stalled result changed")

	// a miss reports id zero
	`NPS_ASSERT(a_miss_id, out_valid && !found |-> nearest_id == '0, "miss with nonzero id")

	// a hit lies below the search ceiling
	`NPS_ASSERT(a_hit_ceiling, out_valid && found |-> nearest_distance_sq < nps_pkg::DIST_OUT_BITS'(nps_pkg::SEARCH_CEILING), "hit at or above ceiling")

	// an accepted query transaction raises in_stall right after acceptance
	`NPS_ASSERT(a_query_busy, in_valid && !in_stall && req_type == nps_pkg::REQ_QUERY |=> in_stall, "input open right after query")

endmodule

bind nearest_point_search_unit nps_checker u_nps_checker (.*);

// File: sim/tb_nearest_point_search_unit.sv
// self-checking testbench of the nearest point search unit
// depends on nps_pkg and nearest_point_search_unit; drives both channels with
// random idle and stall cycles and checks every result against its own predictor
module tb_nearest_point_search_unit;
	import nps_pkg::*;

	localparam int SETTLE_CYCLES = 80;	// longest search plus pipeline, with margin
	localparam int MAX_PRINTS    = 100;

	typedef struct {
		logic                   req_type;
		logic [INDEX_BITS-1:0]  entry_index;
		logic [PCOORD_BITS-1:0] point_x;
		logic [PCOORD_BITS-1:0] point_y;
		logic [ID_BITS-1:0]     point_id;
		logic [FRAC_BITS-1:0]   query_x;
		logic [FRAC_BITS-1:0]   query_y;
	} request_t;

	typedef struct {
		logic                     found;
		logic [ID_BITS-1:0]       ident;
		logic [DIST_OUT_BITS-1:0] dist_sq;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// input channel
	logic     in_valid = 1'b0;
	logic     in_stall;
	request_t drv_req = '{default: '0};

	// output channel
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     found;
	logic [ID_BITS-1:0]       nearest_id;
	logic [DIST_OUT_BITS-1:0] nearest_distance_sq;

	// configuration port
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [APB_DATA_BITS-1:0] pwdata = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	// register copies as the predictor sees them
	logic [SIZE_BITS-1:0]  cfg_width = MAP_WIDTH_RST;
	logic [SIZE_BITS-1:0]  cfg_height = MAP_HEIGHT_RST;
	logic [COUNT_BITS-1:0] cfg_count = POINT_COUNT_RST;
	logic [LIMIT_BITS-1:0] cfg_limit = DISTANCE_LIMIT_RST;

	// point table copy
	logic [PCOORD_BITS-1:0] pt_x [MAX_POINTS_DEF];
	logic [PCOORD_BITS-1:0] pt_y [MAX_POINTS_DEF];
	logic [ID_BITS-1:0]     pt_id [MAX_POINTS_DEF];

	request_t requests_pending [$];
	answer_t  answers_due [$];

	bit in_taken = 1'b0;	// set at the edge that accepts the driven transaction
	bit calm = 1'b0;	// phase with no idle and no stall cycles
	int gap_left = 0;
	int stall_left = 0;
	int errors = 0;

	always #5 clk = ~clk;

	nearest_point_search_unit u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.req_type            (drv_req.req_type),
		.entry_index         (drv_req.entry_index),
		.point_x             (drv_req.point_x),
		.point_y             (drv_req.point_y),
		.point_id            (drv_req.point_id),
		.query_x             (drv_req.query_x),
		.query_y             (drv_req.query_y),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.found               (found),
		.nearest_id          (nearest_id),
		.nearest_distance_sq (nearest_distance_sq),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.prdata              (prdata),
		.pready              (pready)
	);

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (errors < MAX_PRINTS) begin
			$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		end
		errors++;
	endtask

	// store updates the table copy, query predicts the nearest point answer
	function automatic void apply_request(input request_t rq);
		answer_t     a;
		int unsigned sx, sy, qx, qy, n, dx, dy, d, best;
		logic [ID_BITS-1:0] best_id;
		bit          any;
		if (rq.req_type == REQ_STORE) begin
			pt_x[rq.entry_index] = rq.point_x;
			pt_y[rq.entry_index] = rq.point_y;
			pt_id[rq.entry_index] = rq.point_id;
		end else begin
			// map size saturates at the largest map
			sx = (cfg_width > MAP_MAX) ? MAP_MAX : cfg_width;
			sy = (cfg_height > MAP_MAX) ? MAP_MAX : cfg_height;
			qx = (32'(rq.query_x) * sx) >> FRAC_BITS;
			qy = (32'(rq.query_y) * sy) >> FRAC_BITS;
			n = (cfg_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : cfg_count;
			any = 1'b0;
			best = 0;
			best_id = '0;
			for (int i = 0; i < n; i++) begin
				dx = (qx >= pt_x[i]) ? qx - pt_x[i] : pt_x[i] - qx;
				dy = (qy >= pt_y[i]) ? qy - pt_y[i] : pt_y[i] - qy;
				d = dx * dx + dy * dy;
				// strict compare keeps the first entry on a tie
				if (!any || d < best) begin
					best = d;
					best_id = pt_id[i];
					any = 1'b1;
				end
			end
			a.found = any && best < SEARCH_CEILING && best < cfg_limit;
			a.ident = a.found ? best_id : '0;
			a.dist_sq = DIST_OUT_BITS'(best);
			answers_due.push_back(a);
		end
	endfunction

	// fraction that scales to the given pixel, random when the map size is zero
	function automatic logic [FRAC_BITS-1:0] aim(input int pix, input int unsigned size);
		int unsigned s;
		longint      f;
		s = (size > MAP_MAX) ? MAP_MAX : size;
		if (pix < 0) pix = 0;
		if (s == 0) return FRAC_BITS'($urandom);
		f = (longint'(pix) * 65536 + s - 1) / s;
		return (f > 65535) ? 16'hFFFF : f[15:0];
	endfunction

	function automatic void add_store(input int unsigned idx, input int unsigned x,
			input int unsigned y, input int unsigned id);
		request_t rq;
		rq.req_type = REQ_STORE;
		rq.entry_index = INDEX_BITS'(idx);
		rq.point_x = PCOORD_BITS'(x);
		rq.point_y = PCOORD_BITS'(y);
		rq.point_id = ID_BITS'(id);
		rq.query_x = FRAC_BITS'($urandom);
		rq.query_y = FRAC_BITS'($urandom);
		requests_pending.push_back(rq);
	endfunction

	function automatic void add_query(input int unsigned qx, input int unsigned qy);
		request_t rq;
		rq.req_type = REQ_QUERY;
		rq.entry_index = INDEX_BITS'($urandom);
		rq.point_x = PCOORD_BITS'($urandom);
		rq.point_y = PCOORD_BITS'($urandom);
		rq.point_id = ID_BITS'($urandom);
		rq.query_x = FRAC_BITS'(qx);
		rq.query_y = FRAC_BITS'(qy);
		requests_pending.push_back(rq);
	endfunction

	// setup cycle then access cycle; the register takes the value at the access edge
	task automatic reg_write(input cfg_reg_t r, input logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (r)
			REG_MAP_WIDTH: cfg_width = v[SIZE_BITS-1:0];
			REG_MAP_HEIGHT: cfg_height = v[SIZE_BITS-1:0];
			REG_POINT_COUNT: cfg_count = v[COUNT_BITS-1:0];
			REG_DISTANCE_LIMIT: cfg_limit = v[LIMIT_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// wait until every transaction is sent and answered, then let the search run out
	task automatic settle();
		@(posedge clk);
		while (requests_pending.size() != 0 || in_valid || answers_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one setting of all registers, then a mix of stores and queries
	task automatic random_phase(input int len);
		int unsigned w, h, cnt, lim, n, j, r;
		calm = ($urandom_range(0, 3) == 0);
		case ($urandom_range(0, 5))
			0: w = 0;
			1: w = 1;
			2: w = 4096;
			3: w = 8191;
			default: w = $urandom_range(1, 4096);
		endcase
		case ($urandom_range(0, 5))
			0: h = 0;
			1: h = 1;
			2: h = 4096;
			3: h = 8191;
			default: h = $urandom_range(1, 4096);
		endcase
		case ($urandom_range(0, 7))
			0: cnt = 0;
			1: cnt = 64;
			2: cnt = $urandom_range(65, 127);
			default: cnt = $urandom_range(1, 64);
		endcase
		case ($urandom_range(0, 5))
			0: lim = 0;
			1: lim = 24'hFFFFFF;
			2: lim = $urandom_range(0, 10000000);
			3, 4: lim = $urandom_range(0, 200000);
			default: lim = $urandom_range(0, 5000);
		endcase
		reg_write(REG_MAP_WIDTH, w);
		reg_write(REG_MAP_HEIGHT, h);
		reg_write(REG_POINT_COUNT, cnt);
		reg_write(REG_DISTANCE_LIMIT, lim);
		n = (cnt > MAX_POINTS_DEF) ? MAX_POINTS_DEF : cnt;
		repeat (len) begin
			r = $urandom_range(0, 9);
			if (r < 3) begin
				add_store($urandom_range(0, 63), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 255));
			end else if (r < 7 && n > 0) begin
				// land close to a searched point so that hits and near misses occur
				j = $urandom_range(0, n - 1);
				add_query(aim(int'(pt_x[j]) + int'($urandom_range(0, 60)) - 30, w),
					aim(int'(pt_y[j]) + int'($urandom_range(0, 60)) - 30, h));
			end else if (r == 7) begin
				add_query($urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
					$urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
			end else begin
				add_query($urandom, $urandom);
			end
		end
		settle();
	endtask

	// input driver: hold until accepted, then idle for the drawn gap
	always @(negedge clk) begin : drive_in
		logic nxt_valid;
		nxt_valid = in_valid;
		if (in_valid && !in_taken) begin
			nxt_valid = 1'b1;
		end else if (gap_left > 0) begin
			gap_left--;
			nxt_valid = 1'b0;
		end else if (requests_pending.size() != 0) begin
			drv_req <= requests_pending.pop_front();
			nxt_valid = 1'b1;
			gap_left = calm ? 0 : $urandom_range(0, 19);
		end else begin
			nxt_valid = 1'b0;
		end
		in_taken = 1'b0;
		in_valid <= nxt_valid;
	end

	// output stall: counts down the cycles drawn for the current result
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// monitor of both channels
	always @(posedge clk) begin : watch
		answer_t want;
		if (in_valid && !in_stall) begin
			apply_request(drv_req);
			in_taken = 1'b1;
		end
		if (out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				report_mismatch("unexpected result, distance", nearest_distance_sq, 0);
			end else begin
				want = answers_due.pop_front();
				if (found !== want.found)
					report_mismatch("found", found, want.found);
				if (nearest_id !== want.ident)
					report_mismatch("nearest_id", nearest_id, want.ident);
				if (nearest_distance_sq !== want.dist_sq)
					report_mismatch("nearest_distance_sq", nearest_distance_sq,
						want.dist_sq);
			end
			stall_left = calm ? 0 : $urandom_range(0, 19);
		end
	end

	initial begin
		for (int i = 0; i < MAX_POINTS_DEF; i++) begin
			pt_x[i] = '0;
			pt_y[i] = '0;
			pt_id[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty search at reset settings, then a small table with a tie
		add_query(16'h0000, 16'h0000);
		add_query(16'hFFFF, 16'hFFFF);
		add_store(0, 0, 0, 8'h00);
		add_store(1, 4095, 4095, 8'hFF);
		add_store(2, 512, 512, 8'hA5);
		add_store(3, 512, 512, 8'h5A);
		add_store(63, 4095, 0, 8'h3C);
		settle();

		reg_write(REG_POINT_COUNT, 4);
		reg_write(REG_DISTANCE_LIMIT, 1600);
		add_query(16'h0000, 16'h0000);
		add_query(16'h8000, 16'h8000);	// tie between two equal points
		add_query(16'hFFFF, 16'hFFFF);
		add_query(16'h8A00, 16'h8000);	// distance equal to the limit misses
		add_query(16'h89C0, 16'h8000);	// just below the limit hits
		settle();

		reg_write(REG_MAP_WIDTH, 4096);
		reg_write(REG_MAP_HEIGHT, 4096);
		add_query(16'hFFFF, 16'hFFFF);
		settle();

		// zero width and a height that saturates
		reg_write(REG_MAP_WIDTH, 0);
		reg_write(REG_MAP_HEIGHT, 8191);
		add_query(16'hFFFF, 16'hFFFF);
		settle();

		// distance ceiling with a wide open limit: one query beyond both, one just below the ceiling
		reg_write(REG_MAP_WIDTH, 4096);
		reg_write(REG_MAP_HEIGHT, 4096);
		reg_write(REG_POINT_COUNT, 1);
		reg_write(REG_DISTANCE_LIMIT, 24'hFFFFFF);
		add_query(16'hFFFF, 16'hFFFF);
		add_query(50592, 0);
		settle();

		reg_write(REG_DISTANCE_LIMIT, 0);
		add_query(16'h0000, 16'h0000);
		settle();

		// fill the whole table before the random phases search it
		calm = 1'b1;
		for (int i = 0; i < MAX_POINTS_DEF; i++)
			add_store(i, $urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 255));
		settle();

		repeat (12) random_phase(70);

		if (errors == 0) begin
			$display("tb_nearest_point_search_unit: clean");
		end else begin
			$display("tb_nearest_point_search_unit: errors");
		end
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#(10_000_000);
		$display("tb_nearest_point_search_unit: errors");
		$finish;
	end

endmodule
